>>> sv/qrm_pkg.sv
// qrm_pkg: shared types, constants and a helper function for the quaternion to rotation matrix block
// no dependencies; imported by the pipeline modules

package qrm_pkg;

    localparam int unsigned NUM_ENTRIES = 9;

    // matrix entry positions, row major
    localparam int unsigned IDX_R0C0 = 0;
    localparam int unsigned IDX_R0C1 = 1;
    localparam int unsigned IDX_R0C2 = 2;
    localparam int unsigned IDX_R1C0 = 3;
    localparam int unsigned IDX_R1C1 = 4;
    localparam int unsigned IDX_R1C2 = 5;
    localparam int unsigned IDX_R2C0 = 6;
    localparam int unsigned IDX_R2C1 = 7;
    localparam int unsigned IDX_R2C2 = 8;

    // per stage control that travels with the data
    typedef struct packed {
        logic valid;
        logic zero;
    } qrm_ctl_t;

    function automatic logic is_diag(input int unsigned idx);
        return (idx == IDX_R0C0) || (idx == IDX_R1C1) || (idx == IDX_R2C2);
    endfunction

endpackage

>>> sv/qrm_in_if.sv
// qrm_in_if: valid/ready channel carrying one quaternion item
// no dependencies

interface qrm_in_if #(parameter int DATA_WIDTH = 16);

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] comp_x;
    logic signed [DATA_WIDTH-1:0] comp_y;
    logic signed [DATA_WIDTH-1:0] comp_z;
    logic signed [DATA_WIDTH-1:0] comp_w;

    modport source (output valid, output comp_x, output comp_y, output comp_z,
                    output comp_w, input ready);
    modport sink (input valid, input comp_x, input comp_y, input comp_z,
                  input comp_w, output ready);

endinterface

>>> sv/qrm_out_if.sv
// qrm_out_if: valid/ready channel carrying one rotation matrix item
// no dependencies

interface qrm_out_if #(parameter int DATA_WIDTH = 16);

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] row0_col0;
    logic signed [DATA_WIDTH-1:0] row0_col1;
    logic signed [DATA_WIDTH-1:0] row0_col2;
    logic signed [DATA_WIDTH-1:0] row1_col0;
    logic signed [DATA_WIDTH-1:0] row1_col1;
    logic signed [DATA_WIDTH-1:0] row1_col2;
    logic signed [DATA_WIDTH-1:0] row2_col0;
    logic signed [DATA_WIDTH-1:0] row2_col1;
    logic signed [DATA_WIDTH-1:0] row2_col2;
    logic                         zero_input;

    modport source (output valid, output row0_col0, output row0_col1, output row0_col2,
                    output row1_col0, output row1_col1, output row1_col2,
                    output row2_col0, output row2_col1, output row2_col2,
                    output zero_input, input ready);
    modport sink (input valid, input row0_col0, input row0_col1, input row0_col2,
                  input row1_col0, input row1_col1, input row1_col2,
                  input row2_col0, input row2_col1, input row2_col2,
                  input zero_input, output ready);

endinterface

>>> sv/quaternion_to_rotation_matrix.sv
// quaternion_to_rotation_matrix: top level of the fixed-point quaternion to matrix pipeline
// depends on qrm_pkg, qrm_in_if, qrm_out_if, qrm_front, qrm_div_step, qrm_finish
//
// usage
//   quat carries one quaternion item (comp_x, comp_y, comp_z, comp_w, signed,
//   FRAC_BITS fraction bits); mat carries the nine rotation entries of the
//   normalized quaternion plus zero_input, set when the input was all zero and
//   the identity was given.
//   an item is taken whenever valid and ready are both high on a channel.
//   throughput: one item per cycle, sustained while mat.ready stays high.
//   pipeline: the FRAC_BITS + 2 quotient bits are each produced by one
//   compare-subtract stage, after the product, sum, numerator and sign
//   stages and before the two rounding and saturation stages.
//   reset clears every stage valid bit; the pipeline comes up empty and ready.
//   when the receiver holds mat.ready low the last stage holds its item and
//   the stages behind it keep filling bubbles, so quat.ready drops only once
//   every stage holds an item; nothing is lost or repeated.

module quaternion_to_rotation_matrix
    import qrm_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input  logic      clk,
    input  logic      rst_n,
    qrm_in_if.sink    quat,
    qrm_out_if.source mat
);

    localparam int STEPS = FRAC_BITS + 1;

    qrm_ctl_t                                    ctl_s   [STEPS+1];
    logic                                        ready_s [STEPS+1];
    logic [NUM_ENTRIES-1:0][2*DATA_WIDTH:0]      rem_s   [STEPS+1];
    logic [NUM_ENTRIES-1:0][FRAC_BITS+1:0]       quo_s   [STEPS+1];
    logic [NUM_ENTRIES-1:0]                      sgn_s   [STEPS+1];
    logic [2*DATA_WIDTH:0]                       den_s   [STEPS+1];

    qrm_ctl_t                                    fin_ctl;
    logic [NUM_ENTRIES-1:0][DATA_WIDTH-1:0]      fin_ent;

    qrm_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .quat     (quat),
        .dn_ctl   (ctl_s[0]),
        .dn_ready (ready_s[0]),
        .dn_rem   (rem_s[0]),
        .dn_quo   (quo_s[0]),
        .dn_sgn   (sgn_s[0]),
        .dn_den   (den_s[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        qrm_div_step #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_ctl   (ctl_s[i]),
            .up_ready (ready_s[i]),
            .up_rem   (rem_s[i]),
            .up_quo   (quo_s[i]),
            .up_sgn   (sgn_s[i]),
            .up_den   (den_s[i]),
            .dn_ctl   (ctl_s[i+1]),
            .dn_ready (ready_s[i+1]),
            .dn_rem   (rem_s[i+1]),
            .dn_quo   (quo_s[i+1]),
            .dn_sgn   (sgn_s[i+1]),
            .dn_den   (den_s[i+1])
        );
    end

    qrm_finish #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_ctl   (ctl_s[STEPS]),
        .up_ready (ready_s[STEPS]),
        .up_quo   (quo_s[STEPS]),
        .up_sgn   (sgn_s[STEPS]),
        .dn_ctl   (fin_ctl),
        .dn_ready (mat.ready),
        .dn_ent   (fin_ent)
    );

    // final remainder and divisor are not needed after the last quotient bit
    assign mat.valid      = fin_ctl.valid;
    assign mat.zero_input = fin_ctl.zero;
    assign mat.row0_col0  = fin_ent[IDX_R0C0];
    assign mat.row0_col1  = fin_ent[IDX_R0C1];
    assign mat.row0_col2  = fin_ent[IDX_R0C2];
    assign mat.row1_col0  = fin_ent[IDX_R1C0];
    assign mat.row1_col1  = fin_ent[IDX_R1C1];
    assign mat.row1_col2  = fin_ent[IDX_R1C2];
    assign mat.row2_col0  = fin_ent[IDX_R2C0];
    assign mat.row2_col1  = fin_ent[IDX_R2C1];
    assign mat.row2_col2  = fin_ent[IDX_R2C2];

endmodule

>>> sv/qrm_front.sv
// qrm_front: products, sums, numerators, magnitudes and first quotient bit
// five register stages; depends on qrm_pkg and qrm_in_if

module qrm_front
    import qrm_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    qrm_in_if.sink                                  quat,
    output qrm_ctl_t                                dn_ctl,
    input  logic                                    dn_ready,
    output logic [NUM_ENTRIES-1:0][2*DATA_WIDTH:0]  dn_rem,
    output logic [NUM_ENTRIES-1:0][FRAC_BITS+1:0]   dn_quo,
    output logic [NUM_ENTRIES-1:0]                  dn_sgn,
    output logic [2*DATA_WIDTH:0]                   dn_den
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int NW = PW + 1;
    localparam int MW = NW + 1;
    localparam int QW = FRAC_BITS + 2;

    localparam int NUM_PROD = 10;
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;

    logic en1, en2, en3, en4, en5;

    // stage 1: products
    logic                 v1_reg;
    logic signed [PW-1:0] prod_next [NUM_PROD];
    logic [PW-1:0]        prod_reg  [NUM_PROD];

    // stage 2: squared norm and pair sums
    logic                              v2_reg;
    logic [NW-1:0]                     zx [NUM_PROD];
    logic [NW-1:0]                     sx [NUM_PROD];
    logic [NW-1:0]                     n2_next, n2_reg;
    logic [NUM_ENTRIES-1:0][NW-1:0]    sum_next, sum_reg;

    // stage 3: signed numerators
    qrm_ctl_t                          c3_reg;
    logic                              zero_next;
    logic [NUM_ENTRIES-1:0][MW-1:0]    num_next, num_reg;
    logic [NW-1:0]                     den3_reg;

    // stage 4: sign and magnitude
    qrm_ctl_t                          c4_reg;
    logic [NUM_ENTRIES-1:0][MW-1:0]    neg4;
    logic [NUM_ENTRIES-1:0]            sgn4_next, sgn4_reg;
    logic [NUM_ENTRIES-1:0][NW-1:0]    mag4_next, mag4_reg;
    logic [NW-1:0]                     den4_reg;

    // stage 5: integer quotient bit
    qrm_ctl_t                          c5_reg;
    logic [NUM_ENTRIES-1:0]            ge5;
    logic [NUM_ENTRIES-1:0][NW-1:0]    rem5_next, rem5_reg;
    logic [NUM_ENTRIES-1:0][QW-1:0]    quo5_next, quo5_reg;
    logic [NUM_ENTRIES-1:0]            sgn5_reg;
    logic [NW-1:0]                     den5_reg;

    assign en5 = !c5_reg.valid || dn_ready;
    assign en4 = !c4_reg.valid || en5;
    assign en3 = !c3_reg.valid || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign quat.ready = en1;

    always_comb
    begin
        prod_next[P_XX] = quat.comp_x * quat.comp_x;
        prod_next[P_YY] = quat.comp_y * quat.comp_y;
        prod_next[P_ZZ] = quat.comp_z * quat.comp_z;
        prod_next[P_WW] = quat.comp_w * quat.comp_w;
        prod_next[P_XY] = quat.comp_x * quat.comp_y;
        prod_next[P_XZ] = quat.comp_x * quat.comp_z;
        prod_next[P_YZ] = quat.comp_y * quat.comp_z;
        prod_next[P_WX] = quat.comp_w * quat.comp_x;
        prod_next[P_WY] = quat.comp_w * quat.comp_y;
        prod_next[P_WZ] = quat.comp_w * quat.comp_z;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_PROD; k++)
        begin
            zx[k] = {1'b0, prod_reg[k]};
            sx[k] = {prod_reg[k][PW-1], prod_reg[k]};
        end
        n2_next = zx[P_XX] + zx[P_YY] + zx[P_ZZ] + zx[P_WW];
        sum_next[IDX_R0C0] = zx[P_YY] + zx[P_ZZ];
        sum_next[IDX_R1C1] = zx[P_XX] + zx[P_ZZ];
        sum_next[IDX_R2C2] = zx[P_XX] + zx[P_YY];
        sum_next[IDX_R0C1] = sx[P_XY] + sx[P_WZ];
        sum_next[IDX_R0C2] = sx[P_XZ] - sx[P_WY];
        sum_next[IDX_R1C0] = sx[P_XY] - sx[P_WZ];
        sum_next[IDX_R1C2] = sx[P_YZ] + sx[P_WX];
        sum_next[IDX_R2C0] = sx[P_XZ] + sx[P_WY];
        sum_next[IDX_R2C1] = sx[P_YZ] - sx[P_WX];
    end

    always_comb
    begin
        zero_next = (n2_reg == '0);
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            if (is_diag(k))
            begin
                num_next[k] = {1'b0, n2_reg} - {sum_reg[k], 1'b0};
            end
            else
            begin
                num_next[k] = {sum_reg[k], 1'b0};
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            neg4[k]      = MW'(0) - num_reg[k];
            sgn4_next[k] = num_reg[k][MW-1];
            mag4_next[k] = num_reg[k][MW-1] ? neg4[k][NW-1:0] : num_reg[k][NW-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            ge5[k]       = (mag4_reg[k] >= den4_reg);
            rem5_next[k] = ge5[k] ? (mag4_reg[k] - den4_reg) : mag4_reg[k];
            quo5_next[k] = QW'(ge5[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= quat.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                c3_reg.valid <= v2_reg;
                c3_reg.zero  <= zero_next;
            end
            if (en4)
            begin
                c4_reg <= c3_reg;
            end
            if (en5)
            begin
                c5_reg <= c4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int k = 0; k < NUM_PROD; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (en2)
        begin
            n2_reg  <= n2_next;
            sum_reg <= sum_next;
        end
        if (en3)
        begin
            num_reg  <= num_next;
            den3_reg <= n2_reg;
        end
        if (en4)
        begin
            sgn4_reg <= sgn4_next;
            mag4_reg <= mag4_next;
            den4_reg <= den3_reg;
        end
        if (en5)
        begin
            rem5_reg <= rem5_next;
            quo5_reg <= quo5_next;
            sgn5_reg <= sgn4_reg;
            den5_reg <= den4_reg;
        end
    end

    assign dn_ctl = c5_reg;
    assign dn_rem = rem5_reg;
    assign dn_quo = quo5_reg;
    assign dn_sgn = sgn5_reg;
    assign dn_den = den5_reg;

endmodule

>>> sv/qrm_div_step.sv
// qrm_div_step: one restoring division step for all nine entries, one register stage
// depends on qrm_pkg

module qrm_div_step
    import qrm_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  qrm_ctl_t                                up_ctl,
    output logic                                    up_ready,
    input  logic [NUM_ENTRIES-1:0][2*DATA_WIDTH:0]  up_rem,
    input  logic [NUM_ENTRIES-1:0][FRAC_BITS+1:0]   up_quo,
    input  logic [NUM_ENTRIES-1:0]                  up_sgn,
    input  logic [2*DATA_WIDTH:0]                   up_den,
    output qrm_ctl_t                                dn_ctl,
    input  logic                                    dn_ready,
    output logic [NUM_ENTRIES-1:0][2*DATA_WIDTH:0]  dn_rem,
    output logic [NUM_ENTRIES-1:0][FRAC_BITS+1:0]   dn_quo,
    output logic [NUM_ENTRIES-1:0]                  dn_sgn,
    output logic [2*DATA_WIDTH:0]                   dn_den
);

    localparam int NW = 2 * DATA_WIDTH + 1;
    localparam int QW = FRAC_BITS + 2;

    logic                              en;
    qrm_ctl_t                          ctl_reg;
    logic [NUM_ENTRIES-1:0][NW-1:0]    shl;
    logic [NUM_ENTRIES-1:0][NW:0]      diff;
    logic [NUM_ENTRIES-1:0][NW-1:0]    rem_next, rem_reg;
    logic [NUM_ENTRIES-1:0][QW-1:0]    quo_next, quo_reg;
    logic [NUM_ENTRIES-1:0]            sgn_reg;
    logic [NW-1:0]                     den_reg;

    assign en       = !ctl_reg.valid || dn_ready;
    assign up_ready = en;

    // remainder stays below the divisor, so its top bit is free for the shift
    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            shl[k]      = {up_rem[k][NW-2:0], 1'b0};
            diff[k]     = {1'b0, shl[k]} - {1'b0, up_den};
            rem_next[k] = diff[k][NW] ? shl[k] : diff[k][NW-1:0];
            quo_next[k] = {up_quo[k][QW-2:0], !diff[k][NW]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            sgn_reg <= up_sgn;
            den_reg <= up_den;
        end
    end

    assign dn_ctl = ctl_reg;
    assign dn_rem = rem_reg;
    assign dn_quo = quo_reg;
    assign dn_sgn = sgn_reg;
    assign dn_den = den_reg;

endmodule

>>> sv/qrm_finish.sv
// qrm_finish: rounding, sign, saturation and identity override, two register stages
// depends on qrm_pkg

module qrm_finish
    import qrm_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  qrm_ctl_t                                 up_ctl,
    output logic                                     up_ready,
    input  logic [NUM_ENTRIES-1:0][FRAC_BITS+1:0]    up_quo,
    input  logic [NUM_ENTRIES-1:0]                   up_sgn,
    output qrm_ctl_t                                 dn_ctl,
    input  logic                                     dn_ready,
    output logic [NUM_ENTRIES-1:0][DATA_WIDTH-1:0]   dn_ent
);

    localparam int QW = FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 1;
    localparam int CW = ((RW > DATA_WIDTH) ? RW : DATA_WIDTH) + 1;

    localparam logic [CW-1:0] MAX_POS =
        {{(CW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [CW-1:0] MIN_MAG = MAX_POS + CW'(1);
    localparam logic [CW-1:0] ONE_EXT = CW'(1) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] ONE =
        (ONE_EXT > MAX_POS) ? MAX_POS[DATA_WIDTH-1:0] : ONE_EXT[DATA_WIDTH-1:0];
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic                                    en_a, en_b;
    qrm_ctl_t                                ctl_a_reg, ctl_b_reg;
    logic [NUM_ENTRIES-1:0][QW-1:0]          q_inc;
    logic [NUM_ENTRIES-1:0][RW-1:0]          mag_next, mag_reg;
    logic [NUM_ENTRIES-1:0]                  sgn_reg;
    logic [NUM_ENTRIES-1:0][CW-1:0]          qx;
    logic [NUM_ENTRIES-1:0][CW-1:0]          negq;
    logic [NUM_ENTRIES-1:0][DATA_WIDTH-1:0]  pos_sat, neg_sat;
    logic [NUM_ENTRIES-1:0][DATA_WIDTH-1:0]  ent_next, ent_reg;

    assign en_b     = !ctl_b_reg.valid || dn_ready;
    assign en_a     = !ctl_a_reg.valid || en_b;
    assign up_ready = en_a;

    // round half away from zero on the magnitude
    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            q_inc[k]    = up_quo[k] + QW'(1);
            mag_next[k] = q_inc[k][QW-1:1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            qx[k]      = CW'(mag_reg[k]);
            negq[k]    = CW'(0) - qx[k];
            pos_sat[k] = (qx[k] > MAX_POS) ? MAX_POS[DATA_WIDTH-1:0] : qx[k][DATA_WIDTH-1:0];
            neg_sat[k] = (qx[k] > MIN_MAG) ? MIN_VAL : negq[k][DATA_WIDTH-1:0];
            if (ctl_a_reg.zero)
            begin
                ent_next[k] = is_diag(k) ? ONE : '0;
            end
            else
            begin
                ent_next[k] = sgn_reg[k] ? neg_sat[k] : pos_sat[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            if (en_a)
            begin
                ctl_a_reg <= up_ctl;
            end
            if (en_b)
            begin
                ctl_b_reg <= ctl_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            mag_reg <= mag_next;
            sgn_reg <= up_sgn;
        end
        if (en_b)
        begin
            ent_reg <= ent_next;
        end
    end

    assign dn_ctl = ctl_b_reg;
    assign dn_ent = ent_reg;

endmodule

>>> sv/qrm_checker.sv
// qrm_checker: port-level assertions for quaternion_to_rotation_matrix, with its bind
// depends on quaternion_to_rotation_matrix and its channel interfaces

module qrm_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] r00,
    input logic [DATA_WIDTH-1:0] r01,
    input logic [DATA_WIDTH-1:0] r02,
    input logic [DATA_WIDTH-1:0] r10,
    input logic [DATA_WIDTH-1:0] r11,
    input logic [DATA_WIDTH-1:0] r12,
    input logic [DATA_WIDTH-1:0] r20,
    input logic [DATA_WIDTH-1:0] r21,
    input logic [DATA_WIDTH-1:0] r22,
    input logic                  zero_input
);

    // register stages between the two channels
    localparam int DEPTH = FRAC_BITS + 8;
    localparam int CNW   = $clog2(DEPTH + 1);

    logic [CNW-1:0]            cnt_next, cnt_reg;
    logic [9*DATA_WIDTH:0]     payload;

    assign payload = {r00, r01, r02, r10, r11, r12, r20, r21, r22, zero_input};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && in_ready)
        begin
            cnt_next = cnt_next + CNW'(1);
        end
        if (out_valid && out_ready)
        begin
            cnt_next = cnt_next - CNW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload))
        else $error("result item changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_input |-> r01 == '0 && r02 == '0 && r10 == '0 && r12 == '0
            && r20 == '0 && r21 == '0 && r00 == r11 && r11 == r22)
        else $error("zero quaternion did not give the identity");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != '0)
        else $error("result item without an item in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNW'(DEPTH))
        else $error("more items in flight than pipeline stages");

endmodule

bind quaternion_to_rotation_matrix qrm_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_qrm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (quat.valid),
    .in_ready   (quat.ready),
    .out_valid  (mat.valid),
    .out_ready  (mat.ready),
    .r00        (mat.row0_col0),
    .r01        (mat.row0_col1),
    .r02        (mat.row0_col2),
    .r10        (mat.row1_col0),
    .r11        (mat.row1_col1),
    .r12        (mat.row1_col2),
    .r20        (mat.row2_col0),
    .r21        (mat.row2_col1),
    .r22        (mat.row2_col2),
    .zero_input (mat.zero_input)
);
